@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ECFE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ECFE_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/ecfe_pkg.sv @@
// types, constants and crc function of the escaped crc frame encoder
`timescale 1ns / 1ps

package ecfe_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] MARK_START  = 8'hA5;
  localparam logic [7:0] MARK_END    = 8'hC0;
  localparam logic [7:0] MARK_ESC    = 8'hDB;
  localparam logic [7:0] TYPE_BINARY = 8'h01;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [7:0] ESC_START = 8'hDE;
  localparam logic [7:0] ESC_END   = 8'hDC;
  localparam logic [7:0] ESC_ESC   = 8'hDD;
  localparam logic [7:0] ESC_CR    = 8'hD0;
  localparam logic [7:0] ESC_LF    = 8'hD1;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_END    = 2'd2,
    CMD_DROP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       paired;
    logic       last;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] v;
    v = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

endpackage

@@ hdl/ecfe_escape.sv @@
// byte stuffing of one frame byte into a single or paired symbol
`timescale 1ns / 1ps

module ecfe_escape (
  input  logic [7:0]     byte_i,
  output ecfe_pkg::res_t sym_o
);
  import ecfe_pkg::*;

  always_comb begin
    sym_o = '{first_byte: MARK_ESC, second_byte: 8'h00, paired: 1'b1, last: 1'b0};
    unique case (byte_i)
      MARK_START: sym_o.second_byte = ESC_START;
      MARK_END:   sym_o.second_byte = ESC_END;
      MARK_ESC:   sym_o.second_byte = ESC_ESC;
      CHAR_CR:    sym_o.second_byte = ESC_CR;
      CHAR_LF:    sym_o.second_byte = ESC_LF;
      default: begin
        sym_o.first_byte = byte_i;
        sym_o.paired     = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/escaped_crc_frame_encoder.sv @@
// top level: frame buffer memory, crc and symbol sequencer
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_i (cmd, data_byte)
// result    out        res_valid_o, one cycle    res_o (first_byte, second_byte, paired, last)
//
// start, append and drop requests keep busy low and give no result.
// an end request on an undropped frame of n bytes keeps busy high while the sequencer runs
// and gives n + 5 results at one per cycle, set by the single read port of the frame memory.
// rst_ni clears count, drop flag, crc and sequencer; the frame memory is not cleared.
// results cannot be stalled; the next request is taken while the closing result shows.
`timescale 1ns / 1ps

module escaped_crc_frame_encoder #(
  parameter int unsigned MAX_PAYLOAD = ecfe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ecfe_pkg::req_t req_i,
  output logic           busy,
  output logic           res_valid_o,
  output ecfe_pkg::res_t res_o
);
  import ecfe_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TYPE  = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_CRCLO = 3'd3;
  localparam logic [2:0] S_CRCHI = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] next_idx;
  logic          dropped_q, dropped_d;
  logic [15:0]   crc_q, crc_d;
  logic          res_valid_q, res_valid_d;
  res_t          res_q, res_d;

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rdata_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [7:0]    esc_byte;
  res_t          esc_sym;
  logic          accept;

  assign accept   = start && !busy;
  assign next_idx = idx_q + 1'b1;
  assign wr_addr  = count_q[AW-1:0];

  ecfe_escape u_escape (
    .byte_i (esc_byte),
    .sym_o  (esc_sym)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    dropped_d   = dropped_q;
    crc_d       = crc_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    esc_byte    = TYPE_BINARY;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_START: begin
              count_d   = '0;
              dropped_d = 1'b0;
            end
            CMD_APPEND: begin
              if (!dropped_q) begin
                if (count_q == CW'(MAX_PAYLOAD)) begin
                  dropped_d = 1'b1;
                  count_d   = '0;
                end else begin
                  wr_en   = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end
            end
            CMD_END: begin
              if (!dropped_q) begin
                res_valid_d = 1'b1;
                res_d = '{first_byte: MARK_START, second_byte: 8'h00, paired: 1'b0, last: 1'b0};
                crc_d   = CRC_INIT;
                state_d = S_TYPE;
              end
            end
            CMD_DROP: begin
              dropped_d = 1'b1;
              count_d   = '0;
            end
          endcase
        end
      end
      S_TYPE: begin
        esc_byte    = TYPE_BINARY;
        res_valid_d = 1'b1;
        res_d       = esc_sym;
        crc_d       = crc16_byte(crc_q, TYPE_BINARY);
        idx_d       = '0;
        if (count_q != '0) begin
          rd_en   = 1'b1;
          state_d = S_DATA;
        end else begin
          state_d = S_CRCLO;
        end
      end
      S_DATA: begin
        esc_byte    = rdata_q;
        res_valid_d = 1'b1;
        res_d       = esc_sym;
        crc_d       = crc16_byte(crc_q, rdata_q);
        if (next_idx == count_q) begin
          state_d = S_CRCLO;
        end else begin
          rd_en   = 1'b1;
          rd_addr = next_idx[AW-1:0];
          idx_d   = next_idx;
        end
      end
      S_CRCLO: begin
        esc_byte    = crc_q[7:0];
        res_valid_d = 1'b1;
        res_d       = esc_sym;
        state_d     = S_CRCHI;
      end
      S_CRCHI: begin
        esc_byte    = crc_q[15:8];
        res_valid_d = 1'b1;
        res_d       = esc_sym;
        state_d     = S_END;
      end
      S_END: begin
        res_valid_d = 1'b1;
        res_d = '{first_byte: MARK_END, second_byte: 8'h00, paired: 1'b0, last: 1'b1};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      dropped_q   <= 1'b0;
      crc_q       <= CRC_INIT;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      dropped_q   <= dropped_d;
      crc_q       <= crc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // frame buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.data_byte;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hdl/ecfe_checker.sv @@
// port level checks of the escaped crc frame encoder and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecfe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input ecfe_pkg::req_t req_i,
  input logic           busy,
  input logic           res_valid_o,
  input ecfe_pkg::res_t res_o
);
  import ecfe_pkg::*;

  logic quiet_req;
  logic frame_close;
  logic opens_ok;

  assign quiet_req   = start && !busy && req_i.cmd != CMD_END;
  assign frame_close = res_valid_o && res_o.last;
  assign opens_ok    = !res_valid_o || res_o.first_byte == MARK_START;

  `ECFE_NEVER(a_last_while_busy, res_valid_o && res_o.last && busy, "closing result while busy")
  `ECFE_NEVER(a_body_when_idle, res_valid_o && !res_o.last && !busy, "frame result while idle")
  `ECFE_ASSERT(a_quiet_request, quiet_req |=> !res_valid_o, "result after a quiet request")
  `ECFE_ASSERT(a_frame_opens, frame_close |=> opens_ok, "frame does not open with start marker")

endmodule

bind escaped_crc_frame_encoder ecfe_checker u_ecfe_checker (.*);

@@ sim/tb_escaped_crc_frame_encoder.sv @@
// self-checking testbench of the escaped crc frame encoder with a built-in frame predictor
`timescale 1ns / 1ps

module tb_escaped_crc_frame_encoder;
  import ecfe_pkg::*;

  localparam int unsigned FRAME_DEPTH = MAX_PAYLOAD_DEF;
  localparam int unsigned RANDOM_ITEMS = 208;

  typedef struct {
    req_t req;
    bit   wait_drained;
  } pending_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  pending_req_t pending_reqs_q[$];
  res_t frame_symbols_q[$];

  logic [7:0]  frame_bytes [FRAME_DEPTH];
  int unsigned frame_len = 0;
  bit          frame_dropped = 1'b0;
  logic [15:0] frame_crc = CRC_INIT;

  logic took = 1'b0;
  int unsigned accepted_count = 0;
  int unsigned total_reqs = 0;
  int unsigned errors = 0;

  escaped_crc_frame_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic res_t stuff_byte(logic [7:0] b);
    res_t s;
    s = '{first_byte: MARK_ESC, second_byte: 8'h00, paired: 1'b1, last: 1'b0};
    case (b)
      MARK_START: s.second_byte = ESC_START;
      MARK_END:   s.second_byte = ESC_END;
      MARK_ESC:   s.second_byte = ESC_ESC;
      CHAR_CR:    s.second_byte = ESC_CR;
      CHAR_LF:    s.second_byte = ESC_LF;
      default:    s = '{first_byte: b, second_byte: 8'h00, paired: 1'b0, last: 1'b0};
    endcase
    return s;
  endfunction

  task automatic encode_request(req_t r);
    case (r.cmd)
      CMD_START: begin
        frame_len = 0;
        frame_dropped = 1'b0;
      end
      CMD_APPEND: begin
        if (!frame_dropped) begin
          if (frame_len >= FRAME_DEPTH) begin
            frame_dropped = 1'b1;
            frame_len = 0;
          end else begin
            frame_bytes[frame_len] = r.data_byte;
            frame_len++;
          end
        end
      end
      CMD_END: begin
        if (!frame_dropped) begin
          frame_symbols_q.push_back('{first_byte: MARK_START, second_byte: 8'h00,
                                      paired: 1'b0, last: 1'b0});
          frame_crc = crc_update(CRC_INIT, TYPE_BINARY);
          frame_symbols_q.push_back(stuff_byte(TYPE_BINARY));
          for (int unsigned i = 0; i < frame_len; i++) begin
            frame_crc = crc_update(frame_crc, frame_bytes[i]);
            frame_symbols_q.push_back(stuff_byte(frame_bytes[i]));
          end
          frame_symbols_q.push_back(stuff_byte(frame_crc[7:0]));
          frame_symbols_q.push_back(stuff_byte(frame_crc[15:8]));
          frame_symbols_q.push_back('{first_byte: MARK_END, second_byte: 8'h00,
                                      paired: 1'b0, last: 1'b1});
        end
      end
      default: begin
        frame_dropped = 1'b1;
        frame_len = 0;
      end
    endcase
  endtask

  task automatic add_req(cmd_e cmd, logic [7:0] data, bit wait_drained = 1'b0);
    pending_req_t p;
    p.req.cmd = cmd;
    p.req.data_byte = data;
    p.wait_drained = wait_drained;
    pending_reqs_q.push_back(p);
    total_reqs++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return MARK_START;
      1:       return MARK_END;
      2:       return MARK_ESC;
      3:       return CHAR_CR;
      4:       return CHAR_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_frame();
    int unsigned n;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) n = $urandom_range(6);
    else if (sel < 90) n = $urandom_range(31, 7);
    else n = $urandom_range(33, 32);
    add_req(CMD_START, pick_byte(), $urandom_range(19) == 0);
    for (int unsigned i = 0; i < n; i++) add_req(CMD_APPEND, pick_byte());
    if ($urandom_range(9) == 0) add_req(CMD_DROP, pick_byte());
    add_req(CMD_END, pick_byte());
    if ($urandom_range(4) == 0) add_req(CMD_END, pick_byte());
  endtask

  // driver: present the next request at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_reqs_q.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs_q[0].wait_drained &&
                   (frame_symbols_q.size() != 0 || busy)) begin
        start <= 1'b0;
      end else if (!(accepted_count >= 90 && accepted_count < 160) &&
                   $urandom_range(99) < 10) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        req_i <= pending_reqs_q[0].req;
        pending_reqs_q.pop_front();
      end
    end
  end

  // monitor: take requests into the predictor and check each result
  always @(posedge clk_i) begin
    res_t exp_sym;
    if (rst_ni) begin
      took <= start && !busy;
      if (res_valid_o) begin
        if (frame_symbols_q.size() == 0) begin
          $display("%0t: unexpected result first=%h second=%h paired=%b last=%b", $time,
                   res_o.first_byte, res_o.second_byte, res_o.paired, res_o.last);
          errors++;
        end else begin
          exp_sym = frame_symbols_q.pop_front();
          if (res_o.first_byte !== exp_sym.first_byte ||
              res_o.second_byte !== exp_sym.second_byte ||
              res_o.paired !== exp_sym.paired || res_o.last !== exp_sym.last) begin
            $display("%0t: mismatch expected %h %h %b %b, actual %h %h %b %b",
                     $time, exp_sym.first_byte, exp_sym.second_byte, exp_sym.paired,
                     exp_sym.last, res_o.first_byte, res_o.second_byte, res_o.paired,
                     res_o.last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        encode_request(req_i);
        accepted_count++;
      end
    end else begin
      took <= 1'b0;
    end
  end

  initial begin
    // end with no prior start, then every escaped value
    add_req(CMD_END, 8'h00);
    add_req(CMD_START, 8'hFF);
    add_req(CMD_APPEND, MARK_START);
    add_req(CMD_APPEND, MARK_END);
    add_req(CMD_APPEND, MARK_ESC);
    add_req(CMD_APPEND, CHAR_CR);
    add_req(CMD_APPEND, CHAR_LF);
    add_req(CMD_APPEND, 8'h00);
    add_req(CMD_APPEND, 8'hFF);
    add_req(CMD_END, 8'h55);
    add_req(CMD_END, 8'hAA);
    // drop, ignored append and silent end
    add_req(CMD_DROP, 8'hFF, 1'b1);
    add_req(CMD_APPEND, 8'h12);
    add_req(CMD_END, 8'h00);
    add_req(CMD_START, 8'h00);
    add_req(CMD_END, 8'h00);
    add_req(CMD_APPEND, 8'h7E);
    add_req(CMD_APPEND, 8'h81);
    add_req(CMD_END, 8'h00);
    add_req(CMD_DROP, 8'h00);
    add_req(CMD_START, 8'h00);
    add_req(CMD_END, 8'h00);

    while (total_reqs < 22 + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        add_frame();
      end else begin
        repeat ($urandom_range(4, 1)) add_req(cmd_e'($urandom_range(3)), pick_byte());
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    wait (accepted_count == total_reqs);
    while (frame_symbols_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", frame_symbols_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ecfe_pkg.sv
hdl/ecfe_escape.sv
hdl/escaped_crc_frame_encoder.sv
hdl/ecfe_checker.sv
sim/tb_escaped_crc_frame_encoder.sv
